>>> hw/rtl/anbx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbx_pkg
// Shared types, constants and the NAL header classification function for the
// Annex B start code classifier.
// ----------------------------------------------------------------------------
package anbx_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 3;
  localparam int unsigned ClassW  = 3;
  localparam int unsigned RunW    = 2;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [AddrW-1:0] RegCodecSelect = 3'd0;

  localparam logic             CodecH264 = 1'b0;
  localparam logic             CodecHevc = 1'b1;

  localparam logic [RunW-1:0]  RunMax   = 2'd3;
  localparam logic [RunW-1:0]  RunStart = 2'd2;

  localparam logic [LenW-1:0]  LenNone  = 3'd0;
  localparam logic [LenW-1:0]  LenThree = 3'd3;
  localparam logic [LenW-1:0]  LenFour  = 3'd4;

  localparam logic [ByteW-1:0] ByteZero = 8'h00;
  localparam logic [ByteW-1:0] ByteOne  = 8'h01;
  localparam logic [ByteW-1:0] H264TypeMask = 8'h1F;
  localparam logic [ByteW-1:0] HevcTypeMask = 8'h7E;

  // h.264 nal unit types
  localparam logic [4:0] H264Slice = 5'd5;
  localparam logic [4:0] H264Sei   = 5'd6;
  localparam logic [4:0] H264Sps   = 5'd7;
  localparam logic [4:0] H264Pps   = 5'd8;
  localparam logic [4:0] H264Aud   = 5'd9;

  // hevc nal unit types
  localparam logic [5:0] HevcIrapLo = 6'd16;
  localparam logic [5:0] HevcIrapHi = 6'd21;
  localparam logic [5:0] HevcVps    = 6'd32;
  localparam logic [5:0] HevcSps    = 6'd33;
  localparam logic [5:0] HevcPps    = 6'd34;
  localparam logic [5:0] HevcAud    = 6'd35;
  localparam logic [5:0] HevcSei    = 6'd39;

  typedef enum logic [ClassW-1:0] {
    CLS_NONE  = 3'd0,
    CLS_SPS   = 3'd1,
    CLS_PPS   = 3'd2,
    CLS_VPS   = 3'd3,
    CLS_AUD   = 3'd4,
    CLS_SEI   = 3'd5,
    CLS_IRAP  = 3'd6,
    CLS_OTHER = 3'd7
  } nal_class_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    logic             header_here;
    logic [LenW-1:0]  start_length;
    nal_class_t       nal_class;
    logic             header_missing;
    logic             last;
  } parse_res_t;

  function automatic nal_class_t classify_header(input logic codec,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] h264_bits;
    logic [ByteW-1:0] hevc_bits;
    logic [4:0]       t264;
    logic [5:0]       thevc;
    nal_class_t       cls;
    h264_bits = b & H264TypeMask;
    hevc_bits = b & HevcTypeMask;
    t264  = h264_bits[4:0];
    thevc = hevc_bits[6:1];
    cls   = CLS_OTHER;
    if (codec == CodecH264) begin
      if      (t264 == H264Sps)   cls = CLS_SPS;
      else if (t264 == H264Pps)   cls = CLS_PPS;
      else if (t264 == H264Aud)   cls = CLS_AUD;
      else if (t264 == H264Sei)   cls = CLS_SEI;
      else if (t264 == H264Slice) cls = CLS_IRAP;
    end else begin
      if      (thevc == HevcVps) cls = CLS_VPS;
      else if (thevc == HevcSps) cls = CLS_SPS;
      else if (thevc == HevcPps) cls = CLS_PPS;
      else if (thevc == HevcAud) cls = CLS_AUD;
      else if (thevc == HevcSei) cls = CLS_SEI;
      else if (thevc >= HevcIrapLo && thevc <= HevcIrapHi) cls = CLS_IRAP;
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/anbx_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbx_cfg_regs
// APB-style register port holding the codec select bit.
// ----------------------------------------------------------------------------
module anbx_cfg_regs
  import anbx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output logic                  codec_select
);

  logic codec_select_r;
  logic codec_select_nxt;
  logic hit;

  assign pready = 1'b1;
  // register index is paddr / 4
  assign hit = (paddr[AddrW-1:2] == RegCodecSelect[AddrW-1:2]);

  always_comb begin
    codec_select_nxt = codec_select_r;
    if (psel && penable && pwrite && pready && hit) begin
      codec_select_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_select_r <= CodecH264;
    end else begin
      codec_select_r <= codec_select_nxt;
    end
  end

  assign prdata       = hit ? {{(DataW-1){1'b0}}, codec_select_r} : '0;
  assign codec_select = codec_select_r;

endmodule
`default_nettype wire

>>> hw/rtl/anbx_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbx_parser
// Zero-run tracking, start code detection and NAL header classification for
// one byte; the run state advances when the byte moves on.
// ----------------------------------------------------------------------------
module anbx_parser
  import anbx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic             codec_select,
  input  wire logic [ByteW-1:0] data_byte,
  input  wire logic             last,
  output parse_res_t            res
);

  logic [RunW-1:0] zero_run_r;
  logic [RunW-1:0] zero_run_nxt;
  logic            header_pending_r;
  logic            header_pending_nxt;
  logic            four_byte_r;
  logic            four_byte_nxt;

  always_comb begin
    zero_run_nxt       = zero_run_r;
    header_pending_nxt = header_pending_r;
    four_byte_nxt      = four_byte_r;
    res.byte_out       = data_byte;
    res.header_here    = 1'b0;
    res.start_length   = LenNone;
    res.nal_class      = CLS_NONE;
    res.header_missing = 1'b0;
    res.last           = last;

    priority if (header_pending_r) begin
      res.header_here    = 1'b1;
      res.start_length   = four_byte_r ? LenFour : LenThree;
      res.nal_class      = classify_header(codec_select, data_byte);
      header_pending_nxt = 1'b0;
      four_byte_nxt      = 1'b0;
      zero_run_nxt       = (data_byte == ByteZero) ? RunW'(1) : RunW'(0);
    end else if (data_byte == ByteOne && zero_run_r >= RunStart) begin
      zero_run_nxt = '0;
      if (last) begin
        res.header_missing = 1'b1;
      end else begin
        header_pending_nxt = 1'b1;
        four_byte_nxt      = (zero_run_r == RunMax);
      end
    end else if (data_byte == ByteZero) begin
      if (zero_run_r != RunMax) zero_run_nxt = zero_run_r + RunW'(1);
    end else begin
      zero_run_nxt = '0;
    end

    // start codes never span packets
    if (last) begin
      zero_run_nxt       = '0;
      header_pending_nxt = 1'b0;
      four_byte_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r       <= '0;
      header_pending_r <= 1'b0;
      four_byte_r      <= 1'b0;
    end else if (advance) begin
      zero_run_r       <= zero_run_nxt;
      header_pending_r <= header_pending_nxt;
      four_byte_r      <= four_byte_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/annexb_nal_start_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_nal_start_classifier
// Annex B start code finder and NAL header classifier for H.264 and HEVC.
//
// Input channel: one payload byte per beat (in_data_byte) with a mark on the
// final byte of the packet (in_last_in_packet), valid/stall handshake.
// Result channel: one beat per input beat, carrying the byte unchanged, the
// NAL header flag, the start code length, the header class, the flag for a
// start code that ends the packet, and a copy of the last mark.
// Configuration: APB-style port, register 0 at address 0 selects the header
// rules (0 H.264, 1 HEVC); write it only while the block is idle.
// Path: input beat to result beat through the input register, then the result
// register. Throughput: one beat per cycle while the result is not stalled,
// set by the single register-to-register pass that updates the zero-run state.
// Reset (rst_n low, synchronous): both stages empty, zero-run and pending
// header state cleared, codec select back to H.264.
// Stall: a stalled result holds; the input register keeps filling, and
// in_stall rises only once both the input and result registers are full.
// ----------------------------------------------------------------------------
module annexb_nal_start_classifier
  import anbx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ByteW-1:0] in_data_byte,
  input  wire logic             in_last_in_packet,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [ByteW-1:0] out_byte_out,
  output logic                  out_nal_header_here,
  output logic      [LenW-1:0]  out_start_length,
  output logic      [ClassW-1:0] out_nal_class,
  output logic                  out_header_missing,
  output logic                  out_last_out,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  logic             codec_select;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_last_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  parse_res_t       res;
  parse_res_t       res_r;
  logic             s1_move;
  logic             in_take;

  anbx_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .codec_select (codec_select)
  );

  anbx_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (s1_move),
    .codec_select (codec_select),
    .data_byte    (s1_byte_r),
    .last         (s1_last_r),
    .res          (res)
  );

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_in_packet;
    end
    if (s1_move) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte_out        = res_r.byte_out;
  assign out_nal_header_here = res_r.header_here;
  assign out_start_length    = res_r.start_length;
  assign out_nal_class       = res_r.nal_class;
  assign out_header_missing  = res_r.header_missing;
  assign out_last_out        = res_r.last;

endmodule
`default_nettype wire

>>> hw/rtl/anbx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbx_checker
// Port-level checks on the result channel of the start code classifier.
// ----------------------------------------------------------------------------
module anbx_checker
  import anbx_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [ByteW-1:0]  out_byte_out,
  input wire logic              out_nal_header_here,
  input wire logic [LenW-1:0]   out_start_length,
  input wire logic [ClassW-1:0] out_nal_class,
  input wire logic              out_header_missing,
  input wire logic              out_last_out
);

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_out)
      && $stable(out_nal_class) && $stable(out_start_length))
    else $error("stalled result beat changed");

  a_header_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nal_header_here |->
      (out_start_length == LenThree || out_start_length == LenFour)
      && out_nal_class != CLS_NONE && !out_header_missing)
    else $error("header beat with bad length or class");

  a_no_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_nal_header_here |->
      out_start_length == LenNone && out_nal_class == CLS_NONE)
    else $error("length or class outside a header beat");

  a_missing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_missing |-> out_last_out && out_byte_out == ByteOne)
    else $error("missing header flagged off a packet-ending 01 byte");

endmodule

bind annexb_nal_start_classifier anbx_checker u_anbx_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_byte_out        (out_byte_out),
  .out_nal_header_here (out_nal_header_here),
  .out_start_length    (out_start_length),
  .out_nal_class       (out_nal_class),
  .out_header_missing  (out_header_missing),
  .out_last_out        (out_last_out)
);
`default_nettype wire
